### design/bpa_pkg.sv
// bpa_pkg: shared types and constants of the bitmap page allocator
// opcodes, fixed field widths and the controller/datapath command and status structs
// no dependencies
package bpa_pkg;

   // fixed field widths
   localparam int OP_W      = 3;
   localparam int ADDR_W    = 32;
   localparam int LEN_W     = 32;
   localparam int KB_W      = 23;
   localparam int USED_W    = 17;
   localparam int LIMIT_W   = 17;

   // map word geometry
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;
   localparam logic [BIT_W-1:0] BIT_MAX = 5'd31;

   // wide enough for any page, byte or limit calculation
   localparam int CALC_W    = 40;
   localparam int KB_SHIFT  = 10;

   localparam logic [KB_W-1:0] MEM_KB_RESET = 23'd262144;

   // request opcodes
   localparam logic [OP_W-1:0] OP_INIT    = 3'd0;
   localparam logic [OP_W-1:0] OP_ALLOC   = 3'd1;
   localparam logic [OP_W-1:0] OP_FREE    = 3'd2;
   localparam logic [OP_W-1:0] OP_RESERVE = 3'd3;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

   typedef struct packed {
      logic req_ready;
      logic load;
      logic decode;
      logic setup;
      logic fill;
      logic region_wr;
      logic scan_next;
      logic alloc_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic            req_valid;
      logic [OP_W-1:0] op;
      logic            nonempty;
      logic            last_word;
      logic            fill_last;
      logic            scan_stop;
      logic            word_full;
      logic            fits;
      logic            rsp_busy;
   } status_type;

endpackage

### design/bpa_if.sv
// bpa_if: valid/ready channel interfaces of the bitmap page allocator
// request, response and register write channels; depends on bpa_pkg
interface bpa_req_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::OP_W-1:0]      opcode;
   logic [bpa_pkg::ADDR_W-1:0]    address;
   logic [bpa_pkg::LEN_W-1:0]     length_bytes;

   modport source (output valid, opcode, address, length_bytes, input ready);
   modport sink (input valid, opcode, address, length_bytes, output ready);
endinterface

interface bpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::ADDR_W-1:0]    page_address;
   logic                          granted;
   logic [bpa_pkg::USED_W-1:0]    used_pages;
   logic [bpa_pkg::LIMIT_W-1:0]   page_limit;

   modport source (output valid, page_address, granted, used_pages, page_limit, input ready);
   modport sink (input valid, page_address, granted, used_pages, page_limit, output ready);
endinterface

interface bpa_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::KB_W-1:0]      memory_kb;

   modport source (output valid, memory_kb, input ready);
   modport sink (input valid, memory_kb, output ready);
endinterface

### design/bpa_ram.sv
// bpa_ram: generic single write port, single read port memory with registered read
// no dependencies
module bpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

### design/bpa_ctrl.sv
// bpa_ctrl: sequencer of the bitmap page allocator
// steps each request through decode, map walk or scan and response; depends on bpa_pkg
module bpa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  bpa_pkg::status_type st,
   output bpa_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SETUP,
      S_RANGE_RD,
      S_RANGE_WR,
      S_SCAN_RD,
      S_SCAN_EX,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      from_init_ff, from_init_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      from_init_in = from_init_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.fill = 1'b1;
            if (st.fill_last) begin
               state_in     = from_init_ff ? S_RESP : S_IDLE;
               from_init_in = 1'b0;
            end
         end
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (st.req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            unique case (st.op)
               bpa_pkg::OP_INIT: begin
                  state_in     = S_CLEAR;
                  from_init_in = 1'b1;
               end
               bpa_pkg::OP_ALLOC:   state_in = S_SCAN_RD;
               bpa_pkg::OP_FREE:    state_in = S_SETUP;
               bpa_pkg::OP_RESERVE: state_in = S_SETUP;
               bpa_pkg::OP_RELEASE: state_in = S_SETUP;
               default:             state_in = S_RESP;
            endcase
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = st.nonempty ? S_RANGE_RD : S_RESP;
         end
         S_RANGE_RD: begin
            state_in = S_RANGE_WR;
         end
         S_RANGE_WR: begin
            cmd.region_wr = 1'b1;
            state_in      = st.last_word ? S_RESP : S_RANGE_RD;
         end
         S_SCAN_RD: begin
            state_in = st.scan_stop ? S_RESP : S_SCAN_EX;
         end
         S_SCAN_EX: begin
            priority if (st.word_full) begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end else if (st.fits) begin
               cmd.alloc_wr = 1'b1;
               state_in     = S_RESP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!st.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // reset starts with a sweep that marks every page used
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         from_init_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         from_init_ff <= from_init_in;
      end
   end

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !st.rsp_busy)
      else $error("response loaded over a pending one");

   a_clear_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) && !st.fill_last |=> state_ff == S_CLEAR)
      else $error("map sweep left early");

   a_init_flag: assert property (@(posedge clock) disable iff (reset)
      from_init_ff |-> state_ff == S_CLEAR)
      else $error("init flag set outside the map sweep");

endmodule

### design/bpa_datapath.sv
// bpa_datapath: used map memory, counters, range and scan logic, response register
// driven by bpa_ctrl commands; depends on bpa_pkg, bpa_if and bpa_ram
module bpa_datapath #(
   parameter int NUM_PAGES  = 65536,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   bpa_req_if.sink             req_if,
   bpa_rsp_if.source           rsp_if,
   bpa_csr_if.sink             csr_if,
   input  bpa_pkg::cmd_type    cmd,
   output bpa_pkg::status_type st
);

   localparam int WORDS  = (NUM_PAGES + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
   localparam int HINT_W = $clog2(WORDS + 1);
   localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PG_W   = $clog2(NUM_PAGES);
   localparam int PIX_W  = $clog2(NUM_PAGES + 1);
   localparam int SUM_W  = PIX_W + 1;
   localparam int SH     = $clog2(PAGE_BYTES);
   localparam int FP_W   = bpa_pkg::ADDR_W - SH;
   localparam int CW     = bpa_pkg::CALC_W;
   localparam int OW     = bpa_pkg::OP_W;
   localparam int AD_W   = bpa_pkg::ADDR_W;
   localparam int LN_W   = bpa_pkg::LEN_W;
   localparam int KW     = bpa_pkg::KB_W;
   localparam int BW     = bpa_pkg::BIT_W;
   localparam int WB     = bpa_pkg::WORD_BITS;
   localparam int UW     = bpa_pkg::USED_W;
   localparam int LW     = bpa_pkg::LIMIT_W;

   // control state
   logic [KW-1:0]     mem_kb_ff, mem_kb_in;
   logic [PIX_W-1:0]  cnt_ff, cnt_in;
   logic [PIX_W-1:0]  managed_ff, managed_in;
   logic [HINT_W-1:0] hint_ff, hint_in;
   logic [HINT_W-1:0] ptr_ff, ptr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [OW-1:0]     op_ff, op_in;
   logic [AD_W-1:0]   addr_ff, addr_in;
   logic [LN_W-1:0]   len_ff, len_in;
   logic [PG_W-1:0]   first_ff, first_in;
   logic [PG_W-1:0]   last_ff, last_in;
   logic [PIX_W-1:0]  end_ff, end_in;
   logic [PIX_W-1:0]  k_ff, k_in;
   logic              nonempty_ff, nonempty_in;
   logic              grant_ff, grant_in;
   logic [AD_W-1:0]   paddr_ff, paddr_in;
   logic [AD_W-1:0]   rsp_paddr_ff, rsp_paddr_in;
   logic              rsp_grant_ff, rsp_grant_in;
   logic [UW-1:0]     rsp_used_ff, rsp_used_in;
   logic [LW-1:0]     rsp_limit_ff, rsp_limit_in;

   // combinational
   logic [FP_W-1:0]   first_full;
   logic [CW-1:0]     n_full, end_full, lim_full;
   logic [PIX_W-1:0]  end_clamp, lim;
   logic              first_ok;
   logic [HINT_W-1:0] first_word, last_word_idx, req_word;
   logic [BW-1:0]     lo_bit, hi_bit, free_idx;
   logic [WB-1:0]     mask, region_word, low_free, rdata, wdata;
   logic              last_word, word_full, fits, scan_stop, fill_last, we;
   logic [HINT_W+BW-1:0] alloc_page;
   logic [SUM_W-1:0]  cnt_sum;
   logic [PIX_W-1:0]  cnt_up_k, cnt_dn_k, cnt_up1;

   // request decode: first page and clamped end page
   assign first_full = addr_ff[AD_W-1:SH];
   assign n_full     = (op_ff == bpa_pkg::OP_FREE) ? CW'(1) :
                       CW'(len_ff >> SH) + CW'(|len_ff[SH-1:0]);
   assign end_full   = CW'(first_full) + n_full;
   assign end_clamp  = (end_full > CW'(NUM_PAGES)) ? PIX_W'(NUM_PAGES) : PIX_W'(end_full);
   assign first_ok   = CW'(first_full) < CW'(NUM_PAGES);
   assign req_word   = HINT_W'(first_full >> BW);

   assign lim_full = (CW'(mem_kb_ff) << bpa_pkg::KB_SHIFT) >> SH;
   assign lim      = (lim_full > CW'(NUM_PAGES)) ? PIX_W'(NUM_PAGES) : PIX_W'(lim_full);

   // per word mask of a region walk
   assign first_word    = HINT_W'(first_ff >> BW);
   assign last_word_idx = HINT_W'(last_ff >> BW);
   assign last_word     = ptr_ff == last_word_idx;
   assign lo_bit = (ptr_ff == first_word) ? first_ff[BW-1:0] : '0;
   assign hi_bit = last_word ? last_ff[BW-1:0] : bpa_pkg::BIT_MAX;
   assign mask   = ({WB{1'b1}} << lo_bit) & ({WB{1'b1}} >> (bpa_pkg::BIT_MAX - hi_bit));
   assign region_word = (op_ff == bpa_pkg::OP_RESERVE) ? (rdata | mask) : (rdata & ~mask);

   // lowest clear bit of the word being scanned
   assign low_free = ~rdata & (rdata + WB'(1));
   always_comb begin
      free_idx = '0;
      for (int i = 0; i < WB; i++) begin
         if (low_free[i]) begin
            free_idx = free_idx | BW'(i);
         end
      end
   end
   assign alloc_page = {ptr_ff, free_idx};
   assign word_full  = &rdata;
   assign fits       = CW'(alloc_page) < CW'(managed_ff);
   assign scan_stop  = CW'({ptr_ff, {BW{1'b0}}}) >= CW'(managed_ff);
   assign fill_last  = ptr_ff == HINT_W'(WORDS - 1);

   // saturating count updates
   assign cnt_sum  = SUM_W'(cnt_ff) + SUM_W'(k_ff);
   assign cnt_up_k = (cnt_sum > SUM_W'(NUM_PAGES)) ? PIX_W'(NUM_PAGES) : PIX_W'(cnt_sum);
   assign cnt_dn_k = (cnt_ff > k_ff) ? (cnt_ff - k_ff) : '0;
   assign cnt_up1  = (cnt_ff < PIX_W'(NUM_PAGES)) ? (cnt_ff + PIX_W'(1)) : cnt_ff;

   always_comb begin
      mem_kb_in    = mem_kb_ff;
      cnt_in       = cnt_ff;
      managed_in   = managed_ff;
      hint_in      = hint_ff;
      ptr_in       = ptr_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      end_in       = end_ff;
      k_in         = k_ff;
      nonempty_in  = nonempty_ff;
      grant_in     = grant_ff;
      paddr_in     = paddr_ff;
      rsp_paddr_in = rsp_paddr_ff;
      rsp_grant_in = rsp_grant_ff;
      rsp_used_in  = rsp_used_ff;
      rsp_limit_in = rsp_limit_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_if.valid) begin
         mem_kb_in = csr_if.memory_kb;
      end
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load) begin
         op_in    = req_if.opcode;
         addr_in  = req_if.address;
         len_in   = req_if.length_bytes;
         grant_in = 1'b0;
         paddr_in = '0;
      end
      if (cmd.decode) begin
         first_in    = PG_W'(first_full);
         end_in      = end_clamp;
         nonempty_in = first_ok && (n_full != '0);
         if (op_ff == bpa_pkg::OP_INIT) begin
            managed_in = lim;
            cnt_in     = lim;
            hint_in    = HINT_W'(WORDS);
            ptr_in     = '0;
         end else if (op_ff == bpa_pkg::OP_ALLOC) begin
            ptr_in = hint_ff;
         end else if ((op_ff == bpa_pkg::OP_FREE || op_ff == bpa_pkg::OP_RELEASE) &&
                      first_ok && (req_word < hint_ff)) begin
            // words below the hint hold no free page
            hint_in = req_word;
         end
      end
      if (cmd.setup) begin
         last_in = PG_W'(end_ff - PIX_W'(1));
         k_in    = end_ff - PIX_W'(first_ff);
         ptr_in  = first_word;
      end
      if (cmd.fill || cmd.scan_next) begin
         ptr_in = ptr_ff + HINT_W'(1);
      end
      if (cmd.region_wr) begin
         ptr_in = ptr_ff + HINT_W'(1);
         if (last_word) begin
            cnt_in = (op_ff == bpa_pkg::OP_RESERVE) ? cnt_up_k : cnt_dn_k;
         end
      end
      if (cmd.alloc_wr) begin
         grant_in = 1'b1;
         paddr_in = AD_W'(CW'(alloc_page) << SH);
         cnt_in   = cnt_up1;
         hint_in  = ptr_ff;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_paddr_in = paddr_ff;
         rsp_grant_in = grant_ff;
         rsp_used_in  = UW'(cnt_ff);
         rsp_limit_in = LW'(managed_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_kb_ff    <= bpa_pkg::MEM_KB_RESET;
         cnt_ff       <= '0;
         managed_ff   <= '0;
         hint_ff      <= HINT_W'(WORDS);
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mem_kb_ff    <= mem_kb_in;
         cnt_ff       <= cnt_in;
         managed_ff   <= managed_in;
         hint_ff      <= hint_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      len_ff       <= len_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      end_ff       <= end_in;
      k_ff         <= k_in;
      nonempty_ff  <= nonempty_in;
      grant_ff     <= grant_in;
      paddr_ff     <= paddr_in;
      rsp_paddr_ff <= rsp_paddr_in;
      rsp_grant_ff <= rsp_grant_in;
      rsp_used_ff  <= rsp_used_in;
      rsp_limit_ff <= rsp_limit_in;
   end

   // used map, one bit per page
   assign we = cmd.fill || cmd.region_wr || cmd.alloc_wr;
   always_comb begin
      priority if (cmd.fill) begin
         wdata = {WB{1'b1}};
      end else if (cmd.region_wr) begin
         wdata = region_word;
      end else begin
         wdata = rdata | low_free;
      end
   end

   bpa_ram #(
      .WIDTH (WB),
      .DEPTH (WORDS)
   ) u_map (
      .clock (clock),
      .we    (we),
      .waddr (ptr_ff[AW-1:0]),
      .wdata (wdata),
      .raddr (ptr_ff[AW-1:0]),
      .rdata (rdata)
   );

   assign req_if.ready        = cmd.req_ready;
   assign csr_if.ready        = 1'b1;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.page_address = rsp_paddr_ff;
   assign rsp_if.granted      = rsp_grant_ff;
   assign rsp_if.used_pages   = rsp_used_ff;
   assign rsp_if.page_limit   = rsp_limit_ff;

   assign st.req_valid = req_if.valid;
   assign st.op        = op_ff;
   assign st.nonempty  = nonempty_ff;
   assign st.last_word = last_word;
   assign st.fill_last = fill_last;
   assign st.scan_stop = scan_stop;
   assign st.word_full = word_full;
   assign st.fits      = fits;
   assign st.rsp_busy  = rsp_valid_ff && !rsp_if.ready;

   a_count_bounds: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= PIX_W'(NUM_PAGES)) && (managed_ff <= PIX_W'(NUM_PAGES)))
      else $error("page count or limit beyond the map");

   a_scan_from_hint: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_wr |-> ptr_ff >= hint_ff)
      else $error("page granted below the first-free hint");

   a_reserve_no_drop: assert property (@(posedge clock) disable iff (reset)
      cmd.region_wr && last_word && (op_ff == bpa_pkg::OP_RESERVE) |=>
      cnt_ff >= $past(cnt_ff))
      else $error("reserve lowered the used count");

endmodule

### design/bitmap_page_allocator.sv
// bitmap_page_allocator: top level of the first-fit physical page allocator
// joins bpa_ctrl and bpa_datapath; depends on bpa_pkg and bpa_if
//
// One bit per page tracks used pages in a map memory of ceil(NUM_PAGES/32) words
// (2048 at the default size), one response per request. Map words are read and written
// one word at a time, with the read and write ports both addressed by one word pointer.
// After reset a sweep marks every page used, one word a cycle; no request is taken
// during it, register writes are. Init runs that same sweep before its response. Alloc
// scans map words one at a time, starting from the lowest word that may hold a free page.
// Free page, reserve and free region read and rewrite each map word that the page or
// region covers. A new request is taken while the previous response still waits in the
// output register.
module bitmap_page_allocator #(
   parameter int NUM_PAGES  = 65536,
   parameter int PAGE_BYTES = 4096
) (
   input  logic      clock,
   input  logic      reset,
   bpa_req_if.sink   req_if,
   bpa_rsp_if.source rsp_if,
   bpa_csr_if.sink   csr_if
);

   bpa_pkg::cmd_type    cmd;
   bpa_pkg::status_type st;

   bpa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   bpa_datapath #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if),
      .cmd    (cmd),
      .st     (st)
   );

endmodule

### verif/page_alloc_checker.sv
// page_alloc_checker: watches the request, reply and register channels of the allocator,
// keeps its own page map, count and limit, and compares every reply field by field
// depends on bpa_pkg and the channel interfaces in bpa_if
module page_alloc_checker #(
   parameter int NUM_PAGES  = 65536,
   parameter int PAGE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   bpa_req_if          req_ch,
   bpa_rsp_if          rsp_ch,
   bpa_csr_if          csr_ch,
   output int unsigned field_errors,
   output int unsigned replies_owed
);
   timeunit 1ns;
   timeprecision 1ps;
   import bpa_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0]  page_address;
      logic               granted;
      logic [USED_W-1:0]  used_pages;
      logic [LIMIT_W-1:0] page_limit;
   } page_reply_t;

   bit              frame_used [NUM_PAGES];
   longint unsigned used_frames;
   longint unsigned frame_limit;
   logic [KB_W-1:0] installed_kb;
   page_reply_t     reply_queue [$];
   int unsigned     error_total = 0;

   function automatic void mark_all_used();
      foreach (frame_used[p]) frame_used[p] = 1'b1;
   endfunction

   // every touched page moves the count, whatever its bit held
   function automatic void bump_count(bit up);
      if (up) begin
         if (used_frames < NUM_PAGES) used_frames++;
      end else if (used_frames > 0) begin
         used_frames--;
      end
   endfunction

   function automatic void mark_region(logic [ADDR_W-1:0] start, logic [LEN_W-1:0] bytes,
                                       bit up);
      longint unsigned first_frame;
      longint unsigned stop_frame;
      longint unsigned frame;
      first_frame = 64'(start);
      first_frame = first_frame / PAGE_BYTES;
      stop_frame  = 64'(bytes);
      // rounded-up page count in 64 bits, so no wrap
      stop_frame  = first_frame + (stop_frame + PAGE_BYTES - 1) / PAGE_BYTES;
      if (stop_frame > NUM_PAGES) stop_frame = 64'(NUM_PAGES);
      for (frame = first_frame; frame < stop_frame; frame++) begin
         frame_used[frame] = up;
         bump_count(up);
      end
   endfunction

   function automatic page_reply_t apply_request(logic [OP_W-1:0] op,
                                                 logic [ADDR_W-1:0] addr,
                                                 logic [LEN_W-1:0] len);
      page_reply_t     reply;
      longint unsigned frame;
      reply = '0;
      case (op)
         OP_INIT: begin
            frame       = 64'(installed_kb);
            frame       = (frame << KB_SHIFT) / PAGE_BYTES;
            frame_limit = (frame > NUM_PAGES) ? 64'(NUM_PAGES) : frame;
            used_frames = frame_limit;
            mark_all_used();
         end
         OP_ALLOC: begin
            for (frame = 0; frame < frame_limit; frame++) begin
               if (!frame_used[frame]) begin
                  frame_used[frame]  = 1'b1;
                  bump_count(1'b1);
                  reply.page_address = ADDR_W'(frame * PAGE_BYTES);
                  reply.granted      = 1'b1;
                  break;
               end
            end
         end
         OP_FREE: begin
            frame = 64'(addr);
            frame = frame / PAGE_BYTES;
            if (frame < NUM_PAGES) begin
               frame_used[frame] = 1'b0;
               bump_count(1'b0);
            end
         end
         OP_RESERVE: mark_region(addr, len, 1'b1);
         OP_RELEASE: mark_region(addr, len, 1'b0);
         default: ;
      endcase
      reply.used_pages = used_frames[USED_W-1:0];
      reply.page_limit = frame_limit[LIMIT_W-1:0];
      return reply;
   endfunction

   function automatic void report_error(string what);
      error_total++;
      if (error_total <= 10) $display("allocator reply mismatch: %s", what);
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) report_error($sformatf("%s expected %h, got %h", name, want, got));
   endfunction

   always @(posedge clock) begin
      page_reply_t want;
      if (reset) begin
         mark_all_used();
         used_frames  = 0;
         frame_limit  = 0;
         installed_kb = MEM_KB_RESET;
         reply_queue.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) installed_kb = csr_ch.memory_kb;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (reply_queue.size() == 0) begin
               report_error($sformatf("reply with no request outstanding: %h %b %0d %0d",
                  rsp_ch.page_address, rsp_ch.granted, rsp_ch.used_pages,
                  rsp_ch.page_limit));
            end else begin
               want = reply_queue.pop_front();
               compare_field("page_address", want.page_address, rsp_ch.page_address);
               compare_field("granted", 32'(want.granted), 32'(rsp_ch.granted));
               compare_field("used_pages", 32'(want.used_pages), 32'(rsp_ch.used_pages));
               compare_field("page_limit", 32'(want.page_limit), 32'(rsp_ch.page_limit));
            end
         end
         if (req_ch.valid && req_ch.ready)
            reply_queue.push_back(apply_request(req_ch.opcode, req_ch.address,
                                                req_ch.length_bytes));
      end
      field_errors <= error_total;
      replies_owed <= reply_queue.size();
   end

endmodule

### verif/testbench.sv
// testbench: clock, reset and stimulus for bitmap_page_allocator, with the verdict
// drives directed then random transactions with sender gaps and receiver stalls;
// depends on bpa_pkg, bpa_if, the allocator and page_alloc_checker
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bpa_pkg::*;

   localparam int NUM_PAGES   = 65536;
   localparam int PAGE_BYTES  = 4096;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 52;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned field_errors;
   int unsigned replies_owed;
   int unsigned frame_span;
   bit          rsp_hold_wanted;

   bpa_req_if req_if();
   bpa_rsp_if rsp_if();
   bpa_csr_if csr_if();

   bitmap_page_allocator #(.NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   page_alloc_checker #(.NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES)) frame_check (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_if),
      .rsp_ch       (rsp_if),
      .csr_ch       (csr_if),
      .field_errors (field_errors),
      .replies_owed (replies_owed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin : watchdog
      #40ms;
      $display("bitmap_page_allocator regression: fail");
      $finish;
   end

   task automatic send_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                               logic [LEN_W-1:0] len);
      req_if.valid        <= 1'b1;
      req_if.opcode       <= op;
      req_if.address      <= addr;
      req_if.length_bytes <= len;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic pause_requests(int unsigned cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // pause requests first so the owed count, which the checker registers, includes the last accepted transaction
   task automatic wait_until_quiet();
      pause_requests(1);
      while (replies_owed != 0) @(posedge clock);
   endtask

   task automatic write_memory_kb(logic [KB_W-1:0] kb);
      longint unsigned frames;
      csr_if.valid     <= 1'b1;
      csr_if.memory_kb <= kb;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
      frames     = 64'(kb);
      frames     = (frames << KB_SHIFT) / PAGE_BYTES;
      frame_span = (frames > NUM_PAGES) ? NUM_PAGES : 32'(frames);
   endtask

   function automatic logic [OP_W-1:0] random_opcode();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 3) return OP_INIT;
      if (roll < 40) return OP_ALLOC;
      if (roll < 58) return OP_FREE;
      if (roll < 74) return OP_RESERVE;
      if (roll < 96) return OP_RELEASE;
      return OP_W'(OP_RELEASE + $urandom_range(3, 1));
   endfunction

   // mostly inside the managed range, some near the top of the map, some anywhere
   function automatic logic [ADDR_W-1:0] random_address();
      int unsigned frame;
      case ($urandom_range(11))
         0: return $urandom();
         1: frame = $urandom_range(NUM_PAGES + 3, NUM_PAGES - 4);
         default: frame = $urandom_range(frame_span + 3, 0);
      endcase
      return frame * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1, 0);
   endfunction

   function automatic logic [LEN_W-1:0] random_length();
      case ($urandom_range(39))
         0, 1, 2: return '0;
         3: return $urandom();
         4, 5: return $urandom_range(8, 1) * PAGE_BYTES;
         default: return $urandom_range(6 * PAGE_BYTES, 1);
      endcase
   endfunction

   initial begin : reply_sink
      int unsigned stretch;
      int unsigned style;
      bit          held;
      held = 1'b0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_wanted && !held) begin
            // long stall so the allocator backs up and refuses requests
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            style   = $urandom_range(3);
            stretch = $urandom_range(80, 5);
            repeat (stretch) begin
               case (style)
                  0: rsp_if.ready <= 1'b1;
                  1: rsp_if.ready <= ($urandom_range(3) == 0);
                  2: rsp_if.ready <= 1'($urandom_range(1));
                  default: rsp_if.ready <= ~rsp_if.ready;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned     burst_left;
      bit              use_gaps;
      logic [KB_W-1:0] kb;
      rsp_hold_wanted     = 1'b0;
      frame_span          = NUM_PAGES;
      req_if.valid        <= 1'b0;
      req_if.opcode       <= OP_INIT;
      req_if.address      <= '0;
      req_if.length_bytes <= '0;
      csr_if.valid        <= 1'b0;
      csr_if.memory_kb    <= MEM_KB_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // before any init: empty limit, count floor, undefined opcodes
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_FREE, '0, '0);
      send_request(OP_W'(OP_RELEASE + 1), '1, '1);
      send_request(OP_W'(OP_RELEASE + 2), '0, '0);
      send_request(OP_W'(OP_RELEASE + 3), 32'h5555_AAAA, 32'hAAAA_5555);
      wait_until_quiet();

      write_memory_kb(64);
      send_request(OP_INIT, '0, '0);
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_FREE, '1, '0);
      send_request(OP_RELEASE, '0, 1);
      send_request(OP_RELEASE, 3 * PAGE_BYTES, '0);
      send_request(OP_RELEASE, 4 * PAGE_BYTES, 3 * PAGE_BYTES + 1);
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_ALLOC, '0, '0);
      // whole map both ways: count pinned at the top, then at zero
      send_request(OP_RESERVE, '0, '1);
      send_request(OP_RELEASE, '0, '1);
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_FREE, 32'h0FFF_FFFF, '0);
      send_request(OP_RESERVE, 32'hFFFF_F000, '1);
      send_request(OP_RELEASE, 32'h0FFF_F000, 2 * PAGE_BYTES);
      wait_until_quiet();

      write_memory_kb('0);
      send_request(OP_INIT, '0, '0);
      send_request(OP_ALLOC, '0, '0);
      wait_until_quiet();

      write_memory_kb('1);
      send_request(OP_INIT, '0, '0);
      send_request(OP_ALLOC, '0, '0);
      send_request(OP_FREE, 32'h0FFF_F000, '0);
      send_request(OP_ALLOC, '0, '0);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_until_quiet();
         case (phase)
            1: kb = KB_W'(1 << (KB_W - 1));
            3: kb = KB_W'($urandom_range(262143, 0));
            5: kb = '0;
            7: kb = KB_W'($urandom_range((1 << KB_W) - 1, 262144));
            default: kb = KB_W'($urandom_range(512, 4));
         endcase
         write_memory_kb(kb);
         use_gaps = (phase != 0) && ($urandom_range(3) != 0);
         if (phase == 0) rsp_hold_wanted = 1'b1;
         send_request(OP_INIT, $urandom(), $urandom());
         burst_left = $urandom_range(24, 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_request(random_opcode(), random_address(), random_length());
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(24, 1);
               if (use_gaps) pause_requests($urandom_range(10, 1));
            end
         end
      end

      wait_until_quiet();
      repeat (16) @(posedge clock);
      if (field_errors == 0 && replies_owed == 0) begin
         $display("bitmap_page_allocator regression: pass");
      end else begin
         $display("bitmap_page_allocator regression: fail");
      end
      $finish;
   end

endmodule
